### sv/mroc_pkg.sv
package mroc_pkg;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_BACK = 2'd2
  } dir_e;

  localparam int unsigned DUTY_W   = 16;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned LIMIT_W  = 12;
  localparam int unsigned LIMIT_XW = 16;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_RESTART_DELAY = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CURRENT_LIMIT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DRIVE_DUTY    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RUN_TIMEOUT   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TRIP_TICKS    = 3'd4;

  localparam logic [CNT_W-1:0]   RST_RESTART_DELAY = 16'd300;
  localparam logic [LIMIT_W-1:0] RST_CURRENT_LIMIT = 12'd1657;
  localparam logic [DUTY_W-1:0]  RST_DRIVE_DUTY    = 16'd2040;
  localparam logic [CNT_W-1:0]   RST_RUN_TIMEOUT   = 16'd2500;
  localparam logic [CNT_W-1:0]   RST_TRIP_TICKS    = 16'd200;

  typedef struct packed {
    logic [CNT_W-1:0]   restart_delay;
    logic [LIMIT_W-1:0] current_limit;
    logic [DUTY_W-1:0]  drive_duty;
    logic [CNT_W-1:0]   run_timeout;
    logic [CNT_W-1:0]   trip_ticks;
  } cfg_t;

endpackage

### sv/mroc_regs.sv
module mroc_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mroc_pkg::ADDR_W-1:0]   paddr,
  input  logic [mroc_pkg::DATA_W-1:0]   pwdata,
  output logic [mroc_pkg::DATA_W-1:0]   prdata,
  output mroc_pkg::cfg_t                cfg_o
);

  mroc_pkg::cfg_t                      cfg_q;
  mroc_pkg::cfg_t                      cfg_d;
  logic [mroc_pkg::REG_IDX_W-1:0]      idx;
  logic                                wr_en;

  assign idx   = paddr[mroc_pkg::ADDR_W-1:2];
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        mroc_pkg::REG_RESTART_DELAY: cfg_d.restart_delay = pwdata[mroc_pkg::CNT_W-1:0];
        mroc_pkg::REG_CURRENT_LIMIT: cfg_d.current_limit = pwdata[mroc_pkg::LIMIT_W-1:0];
        mroc_pkg::REG_DRIVE_DUTY:    cfg_d.drive_duty    = pwdata[mroc_pkg::DUTY_W-1:0];
        mroc_pkg::REG_RUN_TIMEOUT:   cfg_d.run_timeout   = pwdata[mroc_pkg::CNT_W-1:0];
        mroc_pkg::REG_TRIP_TICKS:    cfg_d.trip_ticks    = pwdata[mroc_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      mroc_pkg::REG_RESTART_DELAY: prdata = {16'd0, cfg_q.restart_delay};
      mroc_pkg::REG_CURRENT_LIMIT: prdata = {20'd0, cfg_q.current_limit};
      mroc_pkg::REG_DRIVE_DUTY:    prdata = {16'd0, cfg_q.drive_duty};
      mroc_pkg::REG_RUN_TIMEOUT:   prdata = {16'd0, cfg_q.run_timeout};
      mroc_pkg::REG_TRIP_TICKS:    prdata = {16'd0, cfg_q.trip_ticks};
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.restart_delay <= mroc_pkg::RST_RESTART_DELAY;
      cfg_q.current_limit <= mroc_pkg::RST_CURRENT_LIMIT;
      cfg_q.drive_duty    <= mroc_pkg::RST_DRIVE_DUTY;
      cfg_q.run_timeout   <= mroc_pkg::RST_RUN_TIMEOUT;
      cfg_q.trip_ticks    <= mroc_pkg::RST_TRIP_TICKS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### sv/mroc_ctrl.sv
module mroc_ctrl #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  mroc_pkg::cfg_t                cfg_i,
  input  logic                          switch_level_i,
  input  logic [SAMPLE_BITS-1:0]        home_current_i,
  input  logic [SAMPLE_BITS-1:0]        front_current_i,
  output logic [mroc_pkg::DUTY_W-1:0]   forward_duty_o,
  output logic [mroc_pkg::DUTY_W-1:0]   backward_duty_o,
  output mroc_pkg::dir_e                direction_o
);

  mroc_pkg::dir_e                 dir_q, dir_d;
  logic [mroc_pkg::CNT_W-1:0]     delay_q, delay_d;
  logic                           pend_q, pend_d;
  logic                           sup_q, sup_d;
  logic [mroc_pkg::CNT_W-1:0]     trip_q, trip_d;
  logic [mroc_pkg::CNT_W-1:0]     timer_q, timer_d;
  logic                           prev_q, prev_d;
  logic                           seen_q, seen_d;
  logic [mroc_pkg::DUTY_W-1:0]    fwd_q, fwd_d;
  logic [mroc_pkg::DUTY_W-1:0]    back_q, back_d;

  logic [mroc_pkg::LIMIT_XW-1:0]  limit_x;
  logic [SAMPLE_BITS-1:0]         limit;
  logic                           front_hot;
  logic                           home_hot;
  logic                           sup_act;

  assign limit_x   = {{(mroc_pkg::LIMIT_XW - mroc_pkg::LIMIT_W){1'b0}}, cfg_i.current_limit};
  assign limit     = limit_x[SAMPLE_BITS-1:0];
  assign front_hot = front_current_i > limit;
  assign home_hot  = home_current_i > limit;

  always_comb begin
    dir_d   = dir_q;
    delay_d = delay_q;
    pend_d  = pend_q;
    sup_d   = sup_q;
    trip_d  = trip_q;
    timer_d = timer_q;
    prev_d  = prev_q;
    seen_d  = seen_q;
    fwd_d   = fwd_q;
    back_d  = back_q;

    if (!seen_q) begin
      dir_d  = mroc_pkg::DIR_STOP;
      seen_d = 1'b1;
      prev_d = switch_level_i;
    end else if (switch_level_i != prev_q) begin
      if (switch_level_i) begin
        dir_d   = mroc_pkg::DIR_FWD;
        delay_d = cfg_i.restart_delay;
        fwd_d   = '0;
        back_d  = '0;
        pend_d  = 1'b1;
        sup_d   = 1'b0;
      end
      prev_d = switch_level_i;
    end

    if (delay_d != '0) begin
      delay_d = delay_d - 16'd1;
    end else if (pend_d) begin
      pend_d = 1'b0;
      if (dir_d == mroc_pkg::DIR_FWD || dir_d == mroc_pkg::DIR_BACK) begin
        fwd_d   = (dir_d == mroc_pkg::DIR_FWD)  ? cfg_i.drive_duty : '0;
        back_d  = (dir_d == mroc_pkg::DIR_BACK) ? cfg_i.drive_duty : '0;
        timer_d = '0;
        sup_d   = 1'b1;
        trip_d  = '0;
      end
    end

    sup_act = sup_d;
    if (sup_act) begin
      if (front_hot) begin
        if (trip_d != '1) trip_d = trip_d + 16'd1;
        if (trip_d > cfg_i.trip_ticks) begin
          dir_d   = mroc_pkg::DIR_BACK;
          delay_d = cfg_i.restart_delay;
          sup_d   = 1'b0;
          pend_d  = 1'b1;
        end
      end
      if (home_hot) begin
        if (trip_d != '1) trip_d = trip_d + 16'd1;
        if (trip_d > cfg_i.trip_ticks) dir_d = mroc_pkg::DIR_STOP;
      end
      if (timer_d < cfg_i.run_timeout) begin
        timer_d = timer_d + 16'd1;
      end else begin
        dir_d   = mroc_pkg::DIR_BACK;
        delay_d = cfg_i.restart_delay;
        sup_d   = 1'b0;
        pend_d  = 1'b1;
      end
    end

    if (dir_d == mroc_pkg::DIR_STOP) begin
      sup_d  = 1'b0;
      fwd_d  = '0;
      back_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q   <= mroc_pkg::DIR_STOP;
      delay_q <= '0;
      pend_q  <= 1'b0;
      sup_q   <= 1'b0;
      trip_q  <= '0;
      timer_q <= '0;
      prev_q  <= 1'b0;
      seen_q  <= 1'b0;
      fwd_q   <= '0;
      back_q  <= '0;
    end else if (step_i) begin
      dir_q   <= dir_d;
      delay_q <= delay_d;
      pend_q  <= pend_d;
      sup_q   <= sup_d;
      trip_q  <= trip_d;
      timer_q <= timer_d;
      prev_q  <= prev_d;
      seen_q  <= seen_d;
      fwd_q   <= fwd_d;
      back_q  <= back_d;
    end
  end

  assign forward_duty_o  = fwd_q;
  assign backward_duty_o = back_q;
  assign direction_o     = dir_q;

  a_sup_not_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sup_q |-> dir_q != mroc_pkg::DIR_STOP)
    else $error("supervision active while stopped");

  a_stop_zero_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dir_q == mroc_pkg::DIR_STOP |-> (fwd_q == '0 && back_q == '0))
    else $error("duty driven while stopped");

  a_one_side_driven: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fwd_q != '0 && back_q != '0))
    else $error("both bridge sides driven");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(dir_q) && $stable(trip_q) && $stable(delay_q))
    else $error("state moved without a step");

endmodule

### sv/motor_reverse_on_overcurrent_top.sv
// Channel   Handshake                   Payload
// in        in_valid_i / in_ready_o     switch_level_i, home_current_i, front_current_i
// out       out_valid_o / out_ready_i   forward_duty_o, backward_duty_o, direction_o
// config    psel/penable/pwrite/pready  paddr, pwdata, prdata
//
// One transaction per cycle sustained while out_ready_i does not stall the result.
// The input register feeds the control step, whose state registers are the result.
// The step fires when the input register holds a transaction and the result register is empty or being taken.
// Reset is asynchronous, active low; config returns to its defaults.
// A stalled result keeps one input transaction buffered, then in_ready_o drops.
module motor_reverse_on_overcurrent_top #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          switch_level_i,
  input  logic [SAMPLE_BITS-1:0]        home_current_i,
  input  logic [SAMPLE_BITS-1:0]        front_current_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mroc_pkg::DUTY_W-1:0]   forward_duty_o,
  output logic [mroc_pkg::DUTY_W-1:0]   backward_duty_o,
  output logic [1:0]                    direction_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mroc_pkg::ADDR_W-1:0]   paddr,
  input  logic [mroc_pkg::DATA_W-1:0]   pwdata,
  output logic [mroc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  mroc_pkg::cfg_t          cfg;
  mroc_pkg::dir_e          dir;
  logic                    in_valid_q, in_valid_d;
  logic                    out_valid_q, out_valid_d;
  logic                    sw_q;
  logic [SAMPLE_BITS-1:0]  home_q;
  logic [SAMPLE_BITS-1:0]  front_q;
  logic                    step;
  logic                    in_acc;

  assign pready     = 1'b1;
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_acc) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sw_q    <= switch_level_i;
      home_q  <= home_current_i;
      front_q <= front_current_i;
    end
  end

  mroc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  mroc_ctrl #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .cfg_i           (cfg),
    .switch_level_i  (sw_q),
    .home_current_i  (home_q),
    .front_current_i (front_q),
    .forward_duty_o  (forward_duty_o),
    .backward_duty_o (backward_duty_o),
    .direction_o     (dir)
  );

  assign direction_o = dir;
  assign out_valid_o = out_valid_q;

endmodule
